### rtl/hack_cpu_instruction_step_defines.svh
// Assertion helpers used by the data memory.
`ifndef HACK_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define HACK_CPU_INSTRUCTION_STEP_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define HCPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define HCPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hcpu_pkg.sv
package hcpu_pkg;

    localparam int WORD_W = 16;
    localparam int PC_W = 15;
    localparam int DATA_WORDS_DEF = 4096;
    localparam int PROGRAM_WORDS_DEF = 32768;

    // Address folding splits the word into two bytes.
    localparam int HALF_W = 8;
    localparam int HALF_SPAN = 1 << HALF_W;

    // Instruction bit positions.
    localparam int INS_CI = 15;
    localparam int INS_AM = 12;
    localparam int INS_FN_LO = 6;
    localparam int INS_FN_HI = 11;
    localparam int INS_DA = 5;
    localparam int INS_DD = 4;
    localparam int INS_DM = 3;
    localparam int INS_JLT = 2;
    localparam int INS_JEQ = 1;
    localparam int INS_JGT = 0;

    // ALU function bit positions.
    localparam int ALU_ZX = 5;
    localparam int ALU_NX = 4;
    localparam int ALU_ZY = 3;
    localparam int ALU_NY = 2;
    localparam int ALU_F = 1;
    localparam int ALU_NO = 0;

    localparam int OUT_TDATA_W = 72;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PC_W-1:0] pc_t;
    typedef logic [5:0] alu_fn_t;

    typedef struct packed {
        logic               halted;
        logic               memory_written;
        logic signed [15:0] alu_out;
        logic signed [15:0] d_value;
        logic signed [15:0] a_value;
        pc_t                next_pc;
    } result_t;

    function automatic word_t hack_alu(word_t x, word_t y, alu_fn_t fn);
        word_t xa;
        word_t ya;
        word_t r;
        xa = fn[ALU_ZX] ? '0 : x;
        xa = fn[ALU_NX] ? ~xa : xa;
        ya = fn[ALU_ZY] ? '0 : y;
        ya = fn[ALU_NY] ? ~ya : ya;
        r = fn[ALU_F] ? word_t'(xa + ya) : (xa & ya);
        r = fn[ALU_NO] ? ~r : r;
        return r;
    endfunction

endpackage

### rtl/hcpu_amod.sv
module hcpu_amod #(
    parameter int DATA_WORDS = hcpu_pkg::DATA_WORDS_DEF
) (
    input  hcpu_pkg::word_t                 a_i,
    output logic [$clog2(DATA_WORDS)-1:0]   addr_o
);
    import hcpu_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [AW:0] MOD_VAL = (AW+1)'(DATA_WORDS);

    // Each byte of A folded into the memory depth by constant tables.
    logic [AW-1:0] hi_tbl [HALF_SPAN];
    logic [AW-1:0] lo_tbl [HALF_SPAN];
    logic [AW:0]   sum;

    for (genvar i = 0; i < HALF_SPAN; i++) begin : g_tbl
        localparam int HI_MOD = (i * HALF_SPAN) % DATA_WORDS;
        localparam int LO_MOD = i % DATA_WORDS;
        assign hi_tbl[i] = AW'(HI_MOD);
        assign lo_tbl[i] = AW'(LO_MOD);
    end

    // Both table entries are below the depth, so one subtraction finishes the fold.
    assign sum = {1'b0, hi_tbl[a_i[WORD_W-1:HALF_W]]} + {1'b0, lo_tbl[a_i[HALF_W-1:0]]};
    assign addr_o = (sum >= MOD_VAL) ? AW'(sum - MOD_VAL) : AW'(sum);

endmodule

### rtl/hcpu_dmem.sv
`include "hack_cpu_instruction_step_defines.svh"

module hcpu_dmem #(
    parameter int DATA_WORDS = hcpu_pkg::DATA_WORDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [$clog2(DATA_WORDS)-1:0]   rd_addr_i,
    input  logic                            wr_en_i,
    input  logic [$clog2(DATA_WORDS)-1:0]   wr_addr_i,
    input  hcpu_pkg::word_t                 wr_data_i,
    output hcpu_pkg::word_t                 rd_data_o,
    output logic                            busy_o
);
    import hcpu_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_WORDS - 1);

    word_t         mem [DATA_WORDS];
    word_t         rd_data_reg;
    word_t         fwd_data_reg;
    logic          fwd_hit_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_busy_reg, clr_busy_next;
    logic          we;
    logic [AW-1:0] waddr;
    word_t         wdata;

    // The clearing sweep owns the write port until every word is zero.
    assign we = clr_busy_reg | wr_en_i;
    assign waddr = clr_busy_reg ? clr_cnt_reg : wr_addr_i;
    assign wdata = clr_busy_reg ? '0 : wr_data_i;

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // The read returns the old word on a collision, so the written word is
    // kept aside and takes its place.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr_i];
        fwd_hit_reg <= we && (waddr == rd_addr_i);
        fwd_data_reg <= wdata;
    end

    assign rd_data_o = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign busy_o = clr_busy_reg;

    `HCPU_ASSERT_NXT(a_fwd_data, aclk, aresetn, we && (waddr == rd_addr_i), rd_data_o == $past(wdata), "read after write to the same word returned stale data")
    `HCPU_ASSERT_IMP(a_sweep_end, aclk, aresetn, $fell(clr_busy_reg), $past(clr_cnt_reg) == LAST_ADDR, "clearing sweep ended before the last word")
    `HCPU_ASSERT_IMP(a_no_wr_in_sweep, aclk, aresetn, clr_busy_reg, !wr_en_i, "instruction wrote memory during the clearing sweep")

endmodule

### rtl/hcpu_core.sv
module hcpu_core #(
    parameter int DATA_WORDS = hcpu_pkg::DATA_WORDS_DEF,
    parameter int PROGRAM_WORDS = hcpu_pkg::PROGRAM_WORDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept_i,
    input  hcpu_pkg::word_t                 instruction_i,
    input  hcpu_pkg::word_t                 mem_rdata_i,
    output logic [$clog2(DATA_WORDS)-1:0]   rd_addr_o,
    output logic                            wr_en_o,
    output logic [$clog2(DATA_WORDS)-1:0]   wr_addr_o,
    output hcpu_pkg::word_t                 wr_data_o,
    output hcpu_pkg::result_t               result_o
);
    import hcpu_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [PC_W:0] PROG_LIMIT = (PC_W+1)'(PROGRAM_WORDS);

    word_t         a_reg, a_next;
    word_t         d_reg, d_next;
    pc_t           pc_reg, pc_next;
    logic [AW-1:0] addr_reg, addr_next;

    logic  is_comp;
    word_t y_opnd;
    word_t res;
    word_t a_new;
    word_t d_new;
    pc_t   pc_new;
    logic  zr;
    logic  ng;
    logic  jump;
    logic  wr_mem;

    // addr_reg always holds A folded into the memory depth.
    hcpu_amod #(
        .DATA_WORDS(DATA_WORDS)
    ) u_amod (
        .a_i   (a_next),
        .addr_o(addr_next)
    );

    always_comb begin
        is_comp = instruction_i[INS_CI];
        y_opnd = instruction_i[INS_AM] ? mem_rdata_i : a_reg;
        res = hack_alu(d_reg, y_opnd, instruction_i[INS_FN_HI:INS_FN_LO]);
        zr = (res == '0);
        ng = res[WORD_W-1];
        jump = (instruction_i[INS_JLT] && ng) || (instruction_i[INS_JEQ] && zr) ||
               (instruction_i[INS_JGT] && !ng && !zr);

        if (!is_comp) begin
            a_new = instruction_i;
        end else if (instruction_i[INS_DA]) begin
            a_new = res;
        end else begin
            a_new = a_reg;
        end
        d_new = (is_comp && instruction_i[INS_DD]) ? res : d_reg;
        pc_new = (is_comp && jump) ? a_reg[PC_W-1:0] : pc_t'(pc_reg + 1'b1);
        wr_mem = is_comp && instruction_i[INS_DM];

        a_next = accept_i ? a_new : a_reg;
        d_next = accept_i ? d_new : d_reg;
        pc_next = accept_i ? pc_new : pc_reg;

        result_o.next_pc = pc_new;
        result_o.a_value = a_new;
        result_o.d_value = d_new;
        result_o.alu_out = is_comp ? res : '0;
        result_o.memory_written = wr_mem;
        result_o.halted = ({1'b0, pc_new} >= PROG_LIMIT);
    end

    // The store goes to the word at A as it stood before this instruction.
    assign wr_en_o = accept_i && wr_mem;
    assign wr_addr_o = addr_reg;
    assign wr_data_o = res;
    assign rd_addr_o = addr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            d_reg <= '0;
            pc_reg <= '0;
            addr_reg <= '0;
        end else begin
            a_reg <= a_next;
            d_reg <= d_next;
            pc_reg <= pc_next;
            addr_reg <= addr_next;
        end
    end

endmodule

### rtl/hcpu_skid.sv
module hcpu_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid_i,
    input  hcpu_pkg::result_t   in_data_i,
    output logic                in_ready_o,
    output logic                out_valid_o,
    input  logic                out_ready_i,
    output hcpu_pkg::result_t   out_data_o
);
    import hcpu_pkg::*;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    always_comb begin
        main_next = main_reg;
        skid_next = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || out_ready_i) begin
            if (skid_valid_reg) begin
                main_next = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next = in_data_i;
                main_valid_next = in_valid_i;
            end
        end else if (in_valid_i) begin
            // Output is stalled: park the new word.
            skid_next = in_data_i;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready_o = !skid_valid_reg;
    assign out_valid_o = main_valid_reg;
    assign out_data_o = main_reg;

endmodule

### rtl/hack_cpu_instruction_step.sv
// Hack-style 16-bit processor that executes one instruction word per accepted
// input word and returns the machine state after it. An instruction is taken
// every clock while the result side keeps up; the result is registered in a
// two-word output buffer, which lets one more instruction in
// while a result is stalled. Data memory is an internal single-write,
// registered-read RAM of DATA_WORDS words whose word at A is read every
// cycle, with a bypass when the same word is written, so an instruction may
// use memory right after A changes. After reset the RAM is cleared in a sweep
// over all DATA_WORDS words, during which s_tready stays low.
module hack_cpu_instruction_step #(
    parameter int DATA_WORDS = hcpu_pkg::DATA_WORDS_DEF,
    parameter int PROGRAM_WORDS = hcpu_pkg::PROGRAM_WORDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  hcpu_pkg::word_t                     s_tdata,  // instruction[15:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // next_pc[14:0], a_value[30:15], d_value[46:31], alu_out[62:47],
    // memory_written[63], halted[64], zero[71:65]
    output logic [hcpu_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import hcpu_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);

    logic          accept;
    logic          buf_ready;
    logic          mem_busy;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    word_t         mem_rdata;
    result_t       core_res;
    result_t       out_res;

    assign s_tready = buf_ready && !mem_busy;
    assign accept = s_tvalid && s_tready;

    hcpu_core #(
        .DATA_WORDS   (DATA_WORDS),
        .PROGRAM_WORDS(PROGRAM_WORDS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept_i     (accept),
        .instruction_i(s_tdata),
        .mem_rdata_i  (mem_rdata),
        .rd_addr_o    (rd_addr),
        .wr_en_o      (wr_en),
        .wr_addr_o    (wr_addr),
        .wr_data_o    (wr_data),
        .result_o     (core_res)
    );

    hcpu_dmem #(
        .DATA_WORDS(DATA_WORDS)
    ) u_dmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr_i(rd_addr),
        .wr_en_i  (wr_en),
        .wr_addr_i(wr_addr),
        .wr_data_i(wr_data),
        .rd_data_o(mem_rdata),
        .busy_o   (mem_busy)
    );

    hcpu_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (accept),
        .in_data_i  (core_res),
        .in_ready_o (buf_ready),
        .out_valid_o(m_tvalid),
        .out_ready_i(m_tready),
        .out_data_o (out_res)
    );

    assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), out_res};

endmodule

### tb/sv/hack_cpu_instruction_step_test.sv
`timescale 1ns / 1ps

module hack_cpu_instruction_step_test;
    import hcpu_pkg::*;

    localparam int RAM_WORDS = DATA_WORDS_DEF;
    localparam int PROG_WORDS = PROGRAM_WORDS_DEF;
    localparam int RANDOM_WORDS = 1200;
    localparam int MAX_IDLE = 18;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    // Standard ALU function codes (zx nx zy ny f no), x = D, y = A or M.
    localparam alu_fn_t FN_ZERO = 6'b101010;
    localparam alu_fn_t FN_ONE = 6'b111111;
    localparam alu_fn_t FN_NEG1 = 6'b111010;
    localparam alu_fn_t FN_X = 6'b001100;
    localparam alu_fn_t FN_Y = 6'b110000;
    localparam alu_fn_t FN_NOTX = 6'b001101;
    localparam alu_fn_t FN_NOTY = 6'b110001;
    localparam alu_fn_t FN_NEGX = 6'b001111;
    localparam alu_fn_t FN_NEGY = 6'b110011;
    localparam alu_fn_t FN_XP1 = 6'b011111;
    localparam alu_fn_t FN_YP1 = 6'b110111;
    localparam alu_fn_t FN_XM1 = 6'b001110;
    localparam alu_fn_t FN_YM1 = 6'b110010;
    localparam alu_fn_t FN_XPY = 6'b000010;
    localparam alu_fn_t FN_XMY = 6'b010011;
    localparam alu_fn_t FN_YMX = 6'b000111;
    localparam alu_fn_t FN_XANDY = 6'b000000;
    localparam alu_fn_t FN_XORY = 6'b010101;

    // Destination field, bits A D M.
    localparam logic [2:0] DST_NONE = 3'b000;
    localparam logic [2:0] DST_M = 3'b001;
    localparam logic [2:0] DST_D = 3'b010;
    localparam logic [2:0] DST_A = 3'b100;

    // Jump field, bits LT EQ GT.
    localparam logic [2:0] JMP_NONE = 3'b000;
    localparam logic [2:0] JMP_GT = 3'b001;
    localparam logic [2:0] JMP_MAX = 3'b111;

    localparam logic OPND_A = 1'b0;
    localparam logic OPND_M = 1'b1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    word_t s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Architectural state as the predictor sees it.
    word_t arch_a;
    word_t arch_d;
    pc_t arch_pc;
    word_t data_ram [RAM_WORDS];

    result_t pending_states [$];

    int error_count = 0;
    int words_sent = 0;
    int directed_words = 0;
    int results_checked = 0;
    int ram_writes = 0;
    int jumps_taken = 0;
    int cycle_count = 0;
    int sink_wait = 0;
    int hold_left = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    hack_cpu_instruction_step dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_states.size());
            $display("[hack_cpu_instruction_step] ERROR");
            $finish;
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic word_t alu_compute(word_t x, word_t y, alu_fn_t fn);
        word_t xo;
        word_t yo;
        word_t r;
        xo = (x & {WORD_W{~fn[ALU_ZX]}}) ^ {WORD_W{fn[ALU_NX]}};
        yo = (y & {WORD_W{~fn[ALU_ZY]}}) ^ {WORD_W{fn[ALU_NY]}};
        r = fn[ALU_F] ? word_t'(xo + yo) : (xo & yo);
        return r ^ {WORD_W{fn[ALU_NO]}};
    endfunction

    // Executes one word against the predicted state and returns what the
    // block should report afterwards.
    function automatic result_t execute_instruction(word_t ins);
        result_t r;
        word_t old_a;
        word_t y;
        word_t res;
        int unsigned addr;
        pc_t next;
        logic zr;
        logic ng;
        logic take;
        r = '0;
        res = '0;
        old_a = arch_a;
        addr = int'(old_a) % RAM_WORDS;
        next = pc_t'(arch_pc + 1'b1);
        if (!ins[INS_CI]) begin
            arch_a = ins;
        end else begin
            y = ins[INS_AM] ? data_ram[addr] : old_a;
            res = alu_compute(arch_d, y, ins[INS_FN_HI:INS_FN_LO]);
            zr = (res == '0);
            ng = res[WORD_W-1];
            take = (ins[INS_JLT] && ng) || (ins[INS_JEQ] && zr) ||
                   (ins[INS_JGT] && !ng && !zr);
            // Memory write and jump target both use A from before the word.
            if (ins[INS_DM]) begin
                data_ram[addr] = res;
                r.memory_written = 1'b1;
                ram_writes++;
            end
            if (ins[INS_DD]) arch_d = res;
            if (ins[INS_DA]) arch_a = res;
            if (take) begin
                next = old_a[PC_W-1:0];
                jumps_taken++;
            end
        end
        arch_pc = next;
        r.next_pc = next;
        r.a_value = arch_a;
        r.d_value = arch_d;
        r.alu_out = res;
        r.halted = (int'(next) >= PROG_WORDS);
        return r;
    endfunction

    function automatic word_t compute_word(logic opnd, alu_fn_t fn, logic [2:0] dest,
                                           logic [2:0] jmp, logic [1:0] spare = 2'b11);
        return {1'b1, spare, opnd, fn, dest, jmp};
    endfunction

    function automatic word_t pick_address();
        case ($urandom_range(0, 3))
            0: return word_t'($urandom_range(0, 15));
            1: return word_t'(RAM_WORDS * $urandom_range(1, 7) + $urandom_range(0, 15));
            2: return word_t'($urandom_range(16'h7FF0, 16'h7FFF));
            default: return word_t'($urandom_range(0, 16'h7FFF));
        endcase
    endfunction

    task automatic compare_field(string name, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_result(logic [OUT_TDATA_W-1:0] raw);
        result_t got;
        result_t want;
        got = raw[$bits(result_t)-1:0];
        if (pending_states.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word, expected none, got %h", $time, raw);
            return;
        end
        want = pending_states.pop_front();
        results_checked++;
        compare_field("next_pc", WORD_W'(want.next_pc), WORD_W'(got.next_pc));
        compare_field("a_value", want.a_value, got.a_value);
        compare_field("d_value", want.d_value, got.d_value);
        compare_field("alu_out", want.alu_out, got.alu_out);
        compare_field("memory_written", WORD_W'(want.memory_written),
                      WORD_W'(got.memory_written));
        compare_field("halted", WORD_W'(want.halted), WORD_W'(got.halted));
        compare_field("padding", '0, WORD_W'(raw[OUT_TDATA_W-1:$bits(result_t)]));
    endtask

    // Result side: checks every accepted word and stalls at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                sink_wait = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0) && (hold_left == 0);
        end
    end

    task automatic send_word(word_t ins);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ins;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_states.push_back(execute_instruction(ins));
        words_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_states.size() != 0) @(posedge aclk);
    endtask

    task automatic test_alu_functions();
        alu_fn_t fns [18];
        fns = '{FN_ZERO, FN_ONE, FN_NEG1, FN_X, FN_Y, FN_NOTX, FN_NOTY, FN_NEGX, FN_NEGY,
                FN_XP1, FN_YP1, FN_XM1, FN_YM1, FN_XPY, FN_XMY, FN_YMX, FN_XANDY, FN_XORY};
        send_word(16'h1234);
        send_word(compute_word(OPND_A, FN_Y, DST_D, JMP_NONE));
        for (int i = 0; i < 18; i++) begin
            send_word(compute_word(logic'(i % 2), fns[i], 3'((i * 3) % 8), 3'(i % 8)));
        end
    endtask

    task automatic test_special_cases();
        // Address above the RAM depth folds; the write lands at the old A.
        send_word(16'd5000);
        send_word(compute_word(OPND_A, FN_XP1, DST_A | DST_M, JMP_NONE, 2'b00));
        send_word(16'd5000);
        send_word(compute_word(OPND_M, FN_Y, DST_D, JMP_NONE));
        // Greater-than must fail on zero and on a negative result.
        send_word(compute_word(OPND_A, FN_ZERO, DST_D, JMP_GT));
        send_word(compute_word(OPND_A, FN_NEG1, DST_D, JMP_GT, 2'b10));
        // Jump to the top of the program space, then let the PC wrap.
        send_word(16'h7FFF);
        send_word(compute_word(OPND_A, FN_ZERO, DST_NONE, JMP_MAX));
        send_word(16'h0000);
        send_word(16'hFFFF);
    endtask

    task automatic test_random_programs();
        int count;
        count = 0;
        while (count < RANDOM_WORDS) begin
            if (count % 100 == 0) begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on <= ($urandom_range(0, 3) != 0);
            end
            if (count % 300 == 150) wait_for_results();
            if ($urandom_range(0, 9) < 7) begin
                // Set up an address, then operate on it.
                send_word(pick_address());
                send_word({1'b1, 15'($urandom)});
                count += 2;
            end else begin
                send_word(word_t'($urandom));
                count++;
            end
        end
    endtask

    task automatic test_backpressure();
        src_idle_on = 1'b0;
        hold_left <= HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0) send_word(pick_address());
            else send_word({1'b1, 15'($urandom)});
        end
        wait_for_results();
        src_idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        arch_a = '0;
        arch_d = '0;
        arch_pc = '0;
        foreach (data_ram[i]) data_ram[i] = '0;
        @(posedge aclk);
        test_alu_functions();
        test_special_cases();
        directed_words = words_sent;
        wait_for_results();
        test_backpressure();
        test_random_programs();
        wait_for_results();
        repeat (16) @(posedge aclk);
        $display("Executed %0d instruction words (%0d directed), checked %0d results.",
                 words_sent, directed_words, results_checked);
        $display("Predicted %0d memory writes and %0d taken jumps.", ram_writes, jumps_taken);
        if (error_count == 0) begin
            $display("[hack_cpu_instruction_step] OK");
        end else begin
            $display("[hack_cpu_instruction_step] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/hcpu_pkg.sv
rtl/hcpu_amod.sv
rtl/hcpu_dmem.sv
rtl/hcpu_core.sv
rtl/hcpu_skid.sv
rtl/hack_cpu_instruction_step.sv
tb/sv/hack_cpu_instruction_step_test.sv
